// ----- design/ipr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_pkg
// shared types and constants of the invalid pixel repair block
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int unsigned MaxWidthDef = 4096;
  localparam int unsigned MaxHeight   = 4096;

  localparam int unsigned CompW  = 32;           // one color component
  localparam int unsigned PixW   = 3 * CompW;    // red, green, blue
  localparam int unsigned SumW   = CompW + 3;    // sum of up to eight components
  localparam int unsigned DsrW   = 16;           // divisor width
  localparam int unsigned CountW = 4;            // neighbor count, up to eight
  localparam int unsigned RowW   = 12;
  localparam int unsigned HgtW   = 13;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [12:0] WidthRst  = 13'd640;
  localparam logic [12:0] HeightRst = 13'd480;
  localparam logic [15:0] PassRst   = 16'd1;

  localparam logic [2:0] NbLast   = 3'd7;
  localparam logic [1:0] CompLast = 2'd2;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PASS   = 2'd2
  } ipr_cfg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } ipr_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LOAD,
    ST_NB_RD,
    ST_NB_ACC,
    ST_MEAN_CHK,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_UPDATE,
    ST_NDIV_GO,
    ST_NDIV_WAIT,
    ST_OUT
  } ipr_state_e;

  typedef struct packed {
    logic push;
    logic rd_head;
    logic load;
    logic nb_rd;
    logic nb_acc;
    logic div_start;
    logic div_mean;
    logic div_take;
    logic update;
    logic out_load;
  } ipr_cmd_t;

  typedef struct packed {
    logic emit_push;
    logic pending;
    logic bad;
    logic n_zero;
    logic nb_last;
    logic comp_last;
    logic div_done;
    logic out_free;
  } ipr_sts_t;

endpackage
`default_nettype wire

// ----- design/ipr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ipr_div #(
  parameter int unsigned DVW = 35,
  parameter int unsigned DSW = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [DSW-1:0] divisor_i,
  output logic                done_o,
  output logic [DVW-1:0]      quotient_o
);
  localparam int unsigned CW = $clog2(DVW + 1);

  logic           busy_q, done_q;
  logic [CW-1:0]  cnt_q;
  logic [DVW-1:0] dq_q;
  logic [DSW-1:0] rem_q, dsr_q;
  logic [DSW:0]   rem_s, diff;
  logic           ge;

  assign rem_s = {rem_q, dq_q[DVW-1]};
  assign ge    = rem_s >= {1'b0, dsr_q};
  assign diff  = rem_s - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DVW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DVW-2:0], ge};
      rem_q <= ge ? diff[DSW-1:0] : rem_s[DSW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;
endmodule
`default_nettype wire

// ----- design/ipr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_ctrl
// sequencer of one pixel: head read, neighbor sweep, divisions, output
// ----------------------------------------------------------------------------
module ipr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire logic          s_drain_i,
  input  wire ipr_pkg::ipr_sts_t sts_i,
  output logic               s_ready_o,
  output ipr_pkg::ipr_cmd_t  cmd_o
);
  import ipr_pkg::*;

  ipr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          if (s_drain_i == CMD_PIXEL) begin
            if (sts_i.emit_push) state_d = ST_HEAD;
          end else if (sts_i.pending) begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD:      state_d = ST_LOAD;
      ST_LOAD:      state_d = sts_i.bad ? ST_NB_RD : ST_UPDATE;
      ST_NB_RD:     state_d = ST_NB_ACC;
      ST_NB_ACC:    state_d = sts_i.nb_last ? ST_MEAN_CHK : ST_NB_RD;
      ST_MEAN_CHK:  state_d = sts_i.n_zero ? ST_UPDATE : ST_MDIV_GO;
      ST_MDIV_GO:   state_d = ST_MDIV_WAIT;
      ST_MDIV_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.comp_last ? ST_UPDATE : ST_MDIV_GO;
      end
      ST_UPDATE:    state_d = sts_i.bad ? ST_OUT : ST_NDIV_GO;
      ST_NDIV_GO:   state_d = ST_NDIV_WAIT;
      ST_NDIV_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.comp_last ? ST_OUT : ST_NDIV_GO;
      end
      ST_OUT:       if (sts_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.push = s_valid_i && (s_drain_i == CMD_PIXEL);
      end
      ST_HEAD:   cmd_o.rd_head = 1'b1;
      ST_LOAD:   cmd_o.load    = 1'b1;
      ST_NB_RD:  cmd_o.nb_rd   = 1'b1;
      ST_NB_ACC: cmd_o.nb_acc  = 1'b1;
      ST_MDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mean  = 1'b1;
      end
      ST_MDIV_WAIT: begin
        cmd_o.div_mean = 1'b1;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_UPDATE:    cmd_o.update    = 1'b1;
      ST_NDIV_GO:   cmd_o.div_start = 1'b1;
      ST_NDIV_WAIT: cmd_o.div_take  = sts_i.div_done;
      ST_OUT:       cmd_o.out_load  = sts_i.out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/ipr_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipr_dp
// look-ahead and repaired-row memories, positions, sums and output word
// ----------------------------------------------------------------------------
module ipr_dp #(
  parameter int unsigned MAX_WIDTH = ipr_pkg::MaxWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ipr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ipr_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [ipr_pkg::PixW-1:0]    s_pix_i,
  input  wire logic                        s_bad_i,
  input  wire ipr_pkg::ipr_cmd_t           cmd_i,
  output ipr_pkg::ipr_sts_t                sts_o,
  input  wire logic                        m_ready_i,
  output logic                             m_valid_o,
  output logic [ipr_pkg::PixW-1:0]         m_pix_o,
  output logic [1:0]                       m_user_o
);
  import ipr_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned LAD  = MAX_WIDTH + 2;
  localparam int unsigned LAW  = $clog2(LAD);
  localparam int unsigned CNTW = $clog2(LAD + 1);
  localparam int unsigned AW   = CNTW + 1;

  // memories
  logic [PixW-1:0] la_comp_mem [LAD];
  logic            la_flag_mem [LAD];
  logic [PixW-1:0] rr_comp_mem [MAX_WIDTH];
  logic            rr_flag_mem [MAX_WIDTH];

  logic [PixW-1:0] la_rd_q, rr_rd_q;
  logic            la_rd_flag_q, rr_rd_flag_q;

  // control state
  logic [WW-1:0]   width_q;
  logic [HgtW-1:0] height_q;
  logic [DsrW-1:0] pass_q;
  logic [LAW-1:0]  head_q;
  logic [CNTW-1:0] count_q;
  logic [CW-1:0]   col_q;
  logic [RowW-1:0] row_q;
  logic [2:0]      nb_q;
  logic [1:0]      comp_q;
  logic            m_valid_q;

  // payload
  logic [PixW-1:0]        px_q, old_q, upleft_q;
  logic                   bad_q, rep_q, old_flag_q, upleft_flag_q;
  logic [2:0][SumW-1:0]   sum_q;
  logic [CountW-1:0]      n_q;
  logic [PixW-1:0]        m_pix_q;
  logic [1:0]             m_user_q;

  // position flags
  logic up, down, left, right;
  logic [WW:0]   col_inc;
  logic [HgtW:0] row_inc;
  assign col_inc = {1'b0, WW'(col_q)} + (WW + 1)'(1);
  assign row_inc = {1'b0, HgtW'(row_q)} + (HgtW + 1)'(1);
  assign up    = row_q != '0;
  assign down  = row_inc < {1'b0, height_q};
  assign left  = col_q != '0;
  assign right = col_inc < {1'b0, width_q};

  function automatic logic [LAW-1:0] la_wrap(input logic [LAW-1:0] base,
                                             input logic [CNTW-1:0] off);
    logic [AW-1:0] s;
    s = AW'(base) + AW'(off);
    if (s >= AW'(LAD)) s = s - AW'(LAD);
    return s[LAW-1:0];
  endfunction

  // neighbor candidate selection
  logic [CNTW-1:0] wk;
  logic [CNTW-1:0] nb_k;
  logic            nb_cond, nb_from_la;
  logic [CW-1:0]   nb_rr_addr;
  assign wk = CNTW'(width_q);

  always_comb begin
    nb_k       = CNTW'(1);
    nb_cond    = 1'b0;
    nb_from_la = 1'b0;
    nb_rr_addr = col_q;
    case (nb_q)
      3'd0: nb_cond = up && left;
      3'd1: nb_cond = up;
      3'd2: begin
        nb_cond    = up && right;
        nb_rr_addr = col_inc[CW-1:0];
      end
      3'd3: begin
        nb_cond    = left;
        nb_rr_addr = col_q - CW'(1);
      end
      3'd4: begin
        nb_from_la = 1'b1;
        nb_k       = CNTW'(1);
        nb_cond    = right;
      end
      3'd5: begin
        nb_from_la = 1'b1;
        nb_k       = wk - CNTW'(1);
        nb_cond    = down && left;
      end
      3'd6: begin
        nb_from_la = 1'b1;
        nb_k       = wk;
        nb_cond    = down;
      end
      3'd7: begin
        nb_from_la = 1'b1;
        nb_k       = wk + CNTW'(1);
        nb_cond    = down && right;
      end
      default: ;
    endcase
    // look-ahead entries not yet received count as absent
    if (nb_from_la && (nb_k >= count_q)) nb_cond = 1'b0;
  end

  logic [PixW-1:0] nb_pix;
  logic            nb_flag;
  always_comb begin
    if (nb_q == 3'd0) begin
      nb_pix  = upleft_q;
      nb_flag = upleft_flag_q;
    end else if (nb_from_la) begin
      nb_pix  = la_rd_q;
      nb_flag = la_rd_flag_q;
    end else begin
      nb_pix  = rr_rd_q;
      nb_flag = rr_rd_flag_q;
    end
  end

  // memory ports
  logic [LAW-1:0] la_wr_addr, la_rd_addr;
  logic [CW-1:0]  rr_rd_addr;
  assign la_wr_addr = la_wrap(head_q, count_q);
  assign la_rd_addr = cmd_i.rd_head ? head_q : la_wrap(head_q, nb_k);
  assign rr_rd_addr = cmd_i.rd_head ? col_q : nb_rr_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      la_comp_mem[la_wr_addr] <= s_pix_i;
      la_flag_mem[la_wr_addr] <= s_bad_i;
    end
    la_rd_q      <= la_comp_mem[la_rd_addr];
    la_rd_flag_q <= la_flag_mem[la_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rr_comp_mem[col_q] <= px_q;
      rr_flag_mem[col_q] <= bad_q;
    end
    rr_rd_q      <= rr_comp_mem[rr_rd_addr];
    rr_rd_flag_q <= rr_flag_mem[rr_rd_addr];
  end

  // shared divider
  logic [SumW-1:0] div_dvd, div_quo;
  logic [DsrW-1:0] div_dsr;
  logic            div_done;
  assign div_dvd = cmd_i.div_mean ? sum_q[comp_q]
                                  : SumW'(px_q[comp_q*CompW +: CompW]);
  assign div_dsr = cmd_i.div_mean ? DsrW'(n_q) : pass_q;

  ipr_div #(.DVW(SumW), .DSW(DsrW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // config clamping
  logic [12:0] cfg_v;
  logic [WW-1:0]   width_cfg;
  logic [HgtW-1:0] height_cfg;
  assign cfg_v = cfg_data_i[12:0];
  always_comb begin
    if (cfg_v == '0)                    width_cfg = WW'(1);
    else if (32'(cfg_v) > MAX_WIDTH)    width_cfg = WW'(MAX_WIDTH);
    else                                width_cfg = WW'(cfg_v);
    if (cfg_v == '0)                    height_cfg = HgtW'(1);
    else if (32'(cfg_v) > MaxHeight)    height_cfg = HgtW'(MaxHeight);
    else                                height_cfg = cfg_v;
  end

  logic cfg_geom;
  assign cfg_geom = cfg_we_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= (32'(WidthRst) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(WidthRst);
      height_q  <= HeightRst;
      pass_q    <= PassRst;
      head_q    <= '0;
      count_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      nb_q      <= '0;
      comp_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_WIDTH)  width_q  <= width_cfg;
      if (cfg_we_i && cfg_index_i == CFG_HEIGHT) height_q <= height_cfg;
      if (cfg_we_i && cfg_index_i == CFG_PASS) begin
        pass_q <= (cfg_data_i == '0) ? DsrW'(1) : cfg_data_i;
      end

      if (cfg_geom) begin
        head_q  <= '0;
        count_q <= '0;
        col_q   <= '0;
        row_q   <= '0;
      end else if (cmd_i.push) begin
        count_q <= count_q + CNTW'(1);
      end else if (cmd_i.out_load) begin
        head_q  <= la_wrap(head_q, CNTW'(1));
        count_q <= count_q - CNTW'(1);
        if (col_inc >= {1'b0, width_q}) begin
          col_q <= '0;
          row_q <= (row_inc >= {1'b0, height_q}) ? '0 : row_inc[RowW-1:0];
        end else begin
          col_q <= col_inc[CW-1:0];
        end
      end

      if (cmd_i.load)        nb_q <= '0;
      else if (cmd_i.nb_acc) nb_q <= nb_q + 3'd1;

      if (cmd_i.load || cmd_i.update) comp_q <= '0;
      else if (cmd_i.div_take)        comp_q <= comp_q + 2'd1;

      if (cmd_i.out_load)  m_valid_q <= 1'b1;
      else if (m_ready_i)  m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q       <= la_rd_q;
      bad_q      <= la_rd_flag_q;
      rep_q      <= 1'b0;
      old_q      <= rr_rd_q;
      old_flag_q <= rr_rd_flag_q;
      sum_q      <= '0;
      n_q        <= '0;
    end
    if (cmd_i.nb_acc && nb_cond && !nb_flag) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_q[i] + SumW'(nb_pix[i*CompW +: CompW]);
      end
      n_q <= n_q + CountW'(1);
    end
    if (cmd_i.div_take) begin
      px_q[comp_q*CompW +: CompW] <= div_quo[CompW-1:0];
      if (cmd_i.div_mean) begin
        bad_q <= 1'b0;
        rep_q <= 1'b1;
      end
    end
    if (cmd_i.update) begin
      upleft_q      <= old_q;
      upleft_flag_q <= old_flag_q;
    end
    if (cmd_i.out_load) begin
      m_pix_q  <= bad_q ? '0 : px_q;
      m_user_q <= {rep_q, bad_q};
    end
  end

  assign sts_o.emit_push = count_q >= (wk + CNTW'(1));
  assign sts_o.pending   = count_q != '0;
  assign sts_o.bad       = cmd_i.load ? la_rd_flag_q : bad_q;
  assign sts_o.n_zero    = n_q == '0;
  assign sts_o.nb_last   = nb_q == NbLast;
  assign sts_o.comp_last = comp_q == CompLast;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_pix_o   = m_pix_q;
  assign m_user_o  = m_user_q;
endmodule
`default_nettype wire

// ----- design/invalid_pixel_repair_normalize.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// invalid_pixel_repair_normalize
// repairs flagged pixels from a 3x3 neighbor mean and divides by pass count
// ----------------------------------------------------------------------------
// Pixels arrive in scan order. A pixel leaves once the pixel below-right of
// it has arrived, so the block holds width + 1 pixels of look-ahead. Drain
// words flush that look-ahead one pixel at a time. A word is taken only
// while the block is idle. A pixel word that emits nothing is only stored.
// An emitting word runs through one sequencer in these steps:
// - the accept cycle
// - head read, load and update
// - neighbor sweep and count check, when the pixel is flagged
// - 3 divisions by the neighbor count, when a valid neighbor exists
// - 3 divisions by the pass count, when the result is valid
// - the output step, held while the output register is still full
// One shared bit-serial divider performs every division.
// The output register lets the next word enter while a result waits.
// Geometry writes clear positions and drop pending pixels.
module invalid_pixel_repair_normalize #(
  parameter int unsigned MAX_WIDTH = ipr_pkg::MaxWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [ipr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ipr_pkg::CfgW-1:0]    cfg_data_i,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [95:0]                 s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic [1:0]                  s_axis_tuser,  // command, is_invalid
  // output stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [95:0]                      m_axis_tdata,  // red_out, green_out, blue_out
  output logic [1:0]                       m_axis_tuser   // still_invalid, was_repaired
);
  import ipr_pkg::*;

  ipr_cmd_t cmd;
  ipr_sts_t sts;

  // sequencer: one word at a time
  ipr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_drain_i (s_axis_tuser[0]),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  // memories, counters, sums and output register
  ipr_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_pix_i     (s_axis_tdata),
    .s_bad_i     (s_axis_tuser[1]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_pix_o     (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );
endmodule
`default_nettype wire

// ----- sim/tb_invalid_pixel_repair_normalize.sv -----
// ----------------------------------------------------------------------------
// tb_invalid_pixel_repair_normalize
// self-checking bench for the invalid pixel repair and pass normalize block
// ----------------------------------------------------------------------------
// A behavioral model of the one-row look-ahead and the repaired-row buffer
// predicts every output word. Small frames keep the look-ahead short, so
// frame wraps, borders and drains are reached often. Directed tests come
// first, then random frames with flagged pixels and drain words, while both
// stream sides idle at random.
module tb_invalid_pixel_repair_normalize;
  import ipr_pkg::*;

  localparam int unsigned LaDepth = MaxWidthDef + 2;
  localparam int unsigned TailCycles = 600;
  localparam int unsigned HoldCycles = 3000;
  localparam longint unsigned CycleLimit = 64'd3_000_000;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        still_invalid;
    logic        was_repaired;
  } pixel_out_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata;  // red_in, green_in, blue_in
  logic [1:0] s_axis_tuser;   // command, is_invalid
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [95:0] m_axis_tdata;  // red_out, green_out, blue_out
  logic [1:0] m_axis_tuser;   // still_invalid, was_repaired

  invalid_pixel_repair_normalize uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // model state
  int unsigned frame_w, frame_h, divisor;
  logic [31:0] la_comp [LaDepth][3];
  logic        la_bad [LaDepth];
  logic [31:0] row_comp [MaxWidthDef][3];
  logic        row_bad [MaxWidthDef];
  logic [31:0] ul_comp [3];
  logic        ul_bad;
  int unsigned in_col, in_row, out_col, out_row, la_head, la_count;

  pixel_out_t expected_pixels[$];
  int errors;
  int words_sent, words_seen, repairs_seen, invalid_seen;
  longint unsigned cycles;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void model_clear();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    la_head = 0; la_count = 0;
  endfunction

  function automatic void model_reset();
    frame_w = 640; frame_h = 480; divisor = 1;
    ul_bad = 1'b0;
    for (int i = 0; i < 3; i++) ul_comp[i] = '0;
    model_clear();
  endfunction

  // add one neighbor to the running sums unless flagged
  function automatic void add_nb(ref longint unsigned sum[3], ref int unsigned n,
                                 input logic [31:0] c0, c1, c2, input logic bad);
    if (bad) return;
    sum[0] += c0; sum[1] += c1; sum[2] += c2;
    n++;
  endfunction

  // look-ahead neighbor k slots past the head, absent when not yet received
  function automatic void add_la(ref longint unsigned sum[3], ref int unsigned n,
                                 input int unsigned k);
    int unsigned s;
    if (k >= la_count) return;
    s = (la_head + k) % LaDepth;
    add_nb(sum, n, la_comp[s][0], la_comp[s][1], la_comp[s][2], la_bad[s]);
  endfunction

  // retire the head pixel into the expected queue
  function automatic void pop_head_pixel();
    int unsigned c, r, n;
    bit up, down, lt, rt;
    logic [31:0] px [3];
    logic [31:0] old [3];
    logic bad, oldbad, rep;
    longint unsigned sum [3];
    pixel_out_t e;
    c = out_col; r = out_row; n = 0;
    up = r > 0; down = r + 1 < frame_h; lt = c > 0; rt = c + 1 < frame_w;
    bad = la_bad[la_head]; rep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      px[i] = la_comp[la_head][i];
      sum[i] = 0;
    end
    if (bad) begin
      if (up) begin
        if (lt) add_nb(sum, n, ul_comp[0], ul_comp[1], ul_comp[2], ul_bad);
        add_nb(sum, n, row_comp[c][0], row_comp[c][1], row_comp[c][2], row_bad[c]);
        if (rt) add_nb(sum, n, row_comp[c+1][0], row_comp[c+1][1], row_comp[c+1][2],
                       row_bad[c+1]);
      end
      if (lt) add_nb(sum, n, row_comp[c-1][0], row_comp[c-1][1], row_comp[c-1][2],
                     row_bad[c-1]);
      if (rt) add_la(sum, n, 1);
      if (down) begin
        if (lt) add_la(sum, n, frame_w - 1);
        add_la(sum, n, frame_w);
        if (rt) add_la(sum, n, frame_w + 1);
      end
      if (n > 0) begin
        for (int i = 0; i < 3; i++) px[i] = 32'(sum[i] / n);
        bad = 1'b0; rep = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) old[i] = row_comp[c][i];
    oldbad = row_bad[c];
    for (int i = 0; i < 3; i++) begin
      row_comp[c][i] = px[i];
      ul_comp[i] = old[i];
    end
    row_bad[c] = bad;
    ul_bad = oldbad;
    e.red   = bad ? '0 : px[0] / divisor;
    e.green = bad ? '0 : px[1] / divisor;
    e.blue  = bad ? '0 : px[2] / divisor;
    e.still_invalid = bad;
    e.was_repaired = rep;
    expected_pixels.insert(expected_pixels.size(), e);
    la_head = (la_head + 1) % LaDepth;
    la_count--;
    out_col++;
    if (out_col >= frame_w) begin
      out_col = 0;
      out_row++;
      if (out_row >= frame_h) out_row = 0;
    end
  endfunction

  function automatic void model_word(ipr_op_e op, logic [31:0] r, g, b, logic bad);
    int unsigned s;
    if (op == CMD_PIXEL) begin
      s = (la_head + la_count) % LaDepth;
      la_comp[s][0] = r; la_comp[s][1] = g; la_comp[s][2] = b;
      la_bad[s] = bad;
      la_count++;
      in_col++;
      if (in_col >= frame_w) begin
        in_col = 0;
        in_row++;
        if (in_row >= frame_h) in_row = 0;
      end
      if (la_count >= frame_w + 2) pop_head_pixel();
    end else if (la_count > 0) begin
      pop_head_pixel();
    end
  endfunction

  // one word on the input stream, with a random lead-in gap
  task automatic send_word(ipr_op_e op, logic [31:0] r, g, b, logic bad, bit gaps = 1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {b, g, r};
    s_axis_tuser = {bad, op};
    do @(posedge clk_i); while (!s_axis_tready);
    model_word(op, r, g, b, bad);
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(0, 255)) << 16;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(int unsigned bad_pct);
    send_word(CMD_PIXEL, rand_comp(), rand_comp(), rand_comp(),
              $urandom_range(0, 99) < bad_pct);
  endtask

  // block idle: nothing outstanding and the last pixel word settled
  task automatic wait_idle();
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(ipr_cfg_e idx, int unsigned value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
      value = value & 32'h1FFF;
      if (value == 0) value = 1;
      if (idx == CFG_WIDTH) begin
        if (value > MaxWidthDef) value = MaxWidthDef;
        frame_w = value;
      end else begin
        if (value > MaxHeight) value = MaxHeight;
        frame_h = value;
      end
      model_clear();
    end else begin
      divisor = (value & 16'hFFFF) == 0 ? 1 : value & 16'hFFFF;
    end
  endtask

  task automatic flush_lookahead();
    int unsigned k;
    k = la_count;
    repeat (k) send_word(CMD_DRAIN, '0, '0, '0, 1'b0);
  endtask

  // output side: random stalls, occasional long hold-off counted here
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off = 1'b0;
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    pixel_out_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (m_axis_tuser[1]) repairs_seen++;
      if (m_axis_tuser[0]) invalid_seen++;
      if (expected_pixels.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (m_axis_tdata[31:0] !== e.red) begin
          $error("red_out expected %h got %h", e.red, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[63:32] !== e.green) begin
          $error("green_out expected %h got %h", e.green, m_axis_tdata[63:32]); errors++;
        end
        if (m_axis_tdata[95:64] !== e.blue) begin
          $error("blue_out expected %h got %h", e.blue, m_axis_tdata[95:64]); errors++;
        end
        if (m_axis_tuser[0] !== e.still_invalid) begin
          $error("still_invalid expected %b got %b", e.still_invalid, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== e.was_repaired) begin
          $error("was_repaired expected %b got %b", e.was_repaired, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // corners, edges, all-flagged frame, drain on empty, extreme values
  task automatic test_directed();
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 3);
    write_reg(CFG_PASS, 1);
    send_word(CMD_DRAIN, '0, '0, '0, 1'b0);                // nothing pending
    send_word(CMD_PIXEL, '1, '1, '1, 1'b0);
    send_word(CMD_PIXEL, '0, '0, '0, 1'b1);
    send_word(CMD_PIXEL, '1, '0, 32'h0001_0000, 1'b0);
    send_word(CMD_PIXEL, '0, '1, '0, 1'b1);
    send_word(CMD_PIXEL, '1, '1, '1, 1'b1);                 // center flagged
    send_word(CMD_PIXEL, 32'h8000_0000, '1, '0, 1'b0);
    send_word(CMD_PIXEL, '0, '0, '0, 1'b1);
    send_word(CMD_PIXEL, '1, '1, '1, 1'b1);
    send_word(CMD_PIXEL, 32'h5555_5555, 32'hAAAA_AAAA, '1, 1'b1);
    flush_lookahead();                                      // drains before neighbors
    // a fully flagged 2x2 frame stays invalid
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    repeat (4) send_word(CMD_PIXEL, '1, '1, '1, 1'b1);
    flush_lookahead();
    // extreme divisor, 1x1 frame
    write_reg(CFG_PASS, 65535);
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 1);
    send_word(CMD_PIXEL, '1, '1, '1, 1'b0);
    send_word(CMD_PIXEL, '1, '1, '1, 1'b1);
    send_word(CMD_PIXEL, '1, '0, '1, 1'b0);
    flush_lookahead();
    write_reg(CFG_PASS, 0);                                 // taken as one
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    send_word(CMD_PIXEL, 32'h1234_5678, '1, '0, 1'b0);
    flush_lookahead();
  endtask

  // random small frames, mostly pixels, some drains and mid-frame restarts
  task automatic test_random_frames(int unsigned words);
    int unsigned w, h, bad_pct;
    int unsigned sent;
    sent = 0;
    while (sent < words) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      write_reg(CFG_PASS, ($urandom_range(0, 3) == 0) ? $urandom() & 16'hFFFF
                                                       : $urandom_range(1, 4));
      bad_pct = $urandom_range(0, 3) * 30;
      repeat ($urandom_range(w * h, 3 * w * h + 4)) begin
        if ($urandom_range(0, 19) == 0) send_word(CMD_DRAIN, rand_comp(), '0, '0,
                                                  1'($urandom()));
        else send_pixel(bad_pct);
        sent++;
      end
      if ($urandom_range(0, 1) == 0) flush_lookahead();
    end
    flush_lookahead();
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 3);
    write_reg(CFG_PASS, 3);
    hold_off = 1'b1;
    repeat (16) send_word(CMD_PIXEL, rand_comp(), rand_comp(), rand_comp(),
                          1'($urandom()), 0);
    while (hold_off) @(negedge clk_i);
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (12) send_pixel(50);
    flush_lookahead();
  endtask

  // width clamped to the maximum, a short run drained from the look-ahead
  task automatic test_wide_frame();
    write_reg(CFG_WIDTH, 8191);
    write_reg(CFG_HEIGHT, 4096);
    write_reg(CFG_PASS, 2);
    repeat (24) send_word(CMD_PIXEL, rand_comp(), rand_comp(), rand_comp(),
                          $urandom_range(0, 99) < 30, 0);
    flush_lookahead();
    write_reg(CFG_HEIGHT, 8191);
    write_reg(CFG_WIDTH, 4);
  endtask

  initial begin
    cycles = 0; errors = 0; hold_off = 1'b0;
    words_sent = 0; words_seen = 0; repairs_seen = 0; invalid_seen = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = CFG_WIDTH; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    model_reset();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random_frames(500);
    test_wide_frame();
    wait_idle();
    $display("sent %0d words, checked %0d pixels (%0d repaired, %0d left invalid)",
             words_sent, words_seen, repairs_seen, invalid_seen);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
